// ===== src/ptv_pkg.sv =====
package ptv_pkg;

    // pipeline depth from input request to output register
    localparam int NUM_STAGES = 6;

    // field widths
    localparam int POINT_W  = 32;
    localparam int SHIFT_W  = 32;
    localparam int INV_W    = 24;
    localparam int COORD_W  = 16;
    localparam int WEIGHT_W = 17;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_SHIFT_X  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_SHIFT_Y  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SHIFT_Z  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_INV_X    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_INV_Y    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_INV_Z    = 3'd5;
    localparam logic [CFG_AW-1:0] REG_MODE     = 3'd6;

    // interpolation modes
    localparam logic MODE_NEAREST   = 1'b0;
    localparam logic MODE_TRILINEAR = 1'b1;

    // reset value of the reciprocal sizes, 1.0 in Q8.16
    localparam logic [INV_W-1:0] INV_ONE = 24'h01_0000;

    // 1.0 in Q1.16, as a weight factor
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h1_0000;

    // per-stage load strobes from the handshake control
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [WEIGHT_W-1:0]       weight_t;

endpackage

// ===== src/ptv_ctrl.sv =====
module ptv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    input  logic               m_ready,
    output logic               s_ready,
    output logic               m_valid,
    output ptv_pkg::pipe_ctrl_t ctrl
);
    import ptv_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   ready_chain;
    logic [NUM_STAGES-1:0] valid_in;

    // a stage takes new data when it is empty or its content moves on
    always_comb
    begin
        ready_chain[NUM_STAGES] = m_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            ready_chain[k] = !valid_reg[k] || ready_chain[k+1];
        end
    end

    assign valid_in = {valid_reg[NUM_STAGES-2:0], s_valid};

    always_comb
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            valid_next[k] = ready_chain[k] ? valid_in[k] : valid_reg[k];
            ctrl.load[k]  = ready_chain[k] && valid_in[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = ready_chain[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

endmodule

// ===== src/ptv_axis.sv =====
module ptv_axis (
    input  logic                                 clk,
    input  ptv_pkg::pipe_ctrl_t                  ctrl,
    input  logic                                 mode,
    input  logic signed [ptv_pkg::POINT_W-1:0]   point,
    input  logic signed [ptv_pkg::SHIFT_W-1:0]   shift,
    input  logic [ptv_pkg::INV_W-1:0]            inv_size,
    output ptv_pkg::coord_t                      coord,
    output ptv_pkg::weight_t                     w_lo,
    output ptv_pkg::weight_t                     w_hi
);
    import ptv_pkg::*;

    localparam int SUM_W  = POINT_W + 1;
    localparam int MUL_W  = SUM_W + INV_W + 1;
    localparam int PROD_W = SUM_W + INV_W;
    localparam int FRAC_W = 32;
    localparam int INT_W  = PROD_W - FRAC_W;
    localparam int RND_W  = INT_W + 1;

    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [MUL_W-1:0]  mul_full;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [INT_W-1:0]  int_part;
    logic [FRAC_W-1:0]        frac;
    logic                     round_up;
    logic signed [RND_W-1:0]  rounded;
    logic signed [RND_W-1:0]  picked;
    coord_t                   coord_next;
    coord_t                   coord_reg;
    weight_t                  w_lo_reg;
    weight_t                  w_hi_reg;
    weight_t                  w_hi_next;

    // stage 1: translate
    assign sum_next = SUM_W'(point) + SUM_W'(shift);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            sum_reg <= sum_next;
        end
    end

    // stage 2: scale by the reciprocal voxel size, Q.32 result
    assign mul_full = sum_reg * $signed({1'b0, inv_size});

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            prod_reg <= mul_full[PROD_W-1:0];
        end
    end

    // stage 3: floor or round half to even, saturate, weight factors
    assign int_part = prod_reg[PROD_W-1:FRAC_W];
    assign frac     = prod_reg[FRAC_W-1:0];
    assign round_up = frac[FRAC_W-1] && ((|frac[FRAC_W-2:0]) || int_part[0]);
    assign rounded  = RND_W'(int_part) + RND_W'(round_up);
    assign picked   = (mode == MODE_TRILINEAR) ? RND_W'(int_part) : rounded;

    always_comb
    begin
        priority if (picked > RND_W'(32767))
        begin
            coord_next = 16'sh7fff;
        end
        else if (picked < -RND_W'(32768))
        begin
            coord_next = 16'sh8000;
        end
        else
        begin
            coord_next = picked[COORD_W-1:0];
        end
    end

    assign w_hi_next = {1'b0, frac[FRAC_W-1:FRAC_W-16]};

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            coord_reg <= coord_next;
            w_hi_reg  <= w_hi_next;
            w_lo_reg  <= WEIGHT_ONE - w_hi_next;
        end
    end

    assign coord = coord_reg;
    assign w_lo  = w_lo_reg;
    assign w_hi  = w_hi_reg;

endmodule

// ===== src/ptv_weight.sv =====
module ptv_weight (
    input  logic                              clk,
    input  ptv_pkg::pipe_ctrl_t               ctrl,
    input  logic                              mode,
    input  ptv_pkg::coord_t [2:0]             coord_in,
    input  ptv_pkg::weight_t [2:0][1:0]       factor,
    output ptv_pkg::coord_t [2:0]             coord_out,
    output ptv_pkg::weight_t [7:0]            weight
);
    import ptv_pkg::*;

    localparam int PAIR_W = 2 * (WEIGHT_W - 1) + 1;
    localparam int TRIP_W = 3 * (WEIGHT_W - 1) + 1;
    localparam int MUL_W  = PAIR_W + WEIGHT_W;
    localparam int FRAC_W = 32;
    localparam logic [TRIP_W-1:0] HALF = TRIP_W'(64'h8000_0000);

    logic [3:0][PAIR_W-1:0] pair_reg;
    weight_t [1:0]          zf_reg;
    coord_t [2:0]           coord4_reg;
    logic [7:0][TRIP_W-1:0] trip_reg;
    coord_t [2:0]           coord5_reg;
    coord_t [2:0]           coord6_reg;
    weight_t [7:0]          weight_reg;
    weight_t [7:0]          weight_next;
    logic [3:0][PAIR_W-1:0] pair_next;
    logic [7:0][TRIP_W-1:0] trip_next;
    logic [2*WEIGHT_W-1:0]  pair_full;
    logic [MUL_W-1:0]       mul_full;
    logic [TRIP_W-1:0]      rnd_sum;

    // stage 4: x by y products, index is {bx, by}
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            pair_full    = factor[0][k[1]] * factor[1][k[0]];
            pair_next[k] = pair_full[PAIR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            pair_reg   <= pair_next;
            zf_reg     <= factor[2];
            coord4_reg <= coord_in;
        end
    end

    // stage 5: times z, index is {bx, by, bz}
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            mul_full     = pair_reg[k[2:1]] * zf_reg[k[0]];
            trip_next[k] = mul_full[TRIP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            trip_reg   <= trip_next;
            coord5_reg <= coord4_reg;
        end
    end

    // stage 6: round Q1.48 to Q1.16, zero in nearest mode
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            rnd_sum = trip_reg[k] + HALF;
            if (mode == MODE_TRILINEAR)
            begin
                weight_next[k] = rnd_sum[TRIP_W-1:FRAC_W];
            end
            else
            begin
                weight_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            weight_reg <= weight_next;
            coord6_reg <= coord5_reg;
        end
    end

    assign weight    = weight_reg;
    assign coord_out = coord6_reg;

endmodule

// ===== src/point_to_voxel_trilinear_weights_core.sv =====
// channel   | dir | handshake             | payload (lowest bit up)
// s_axis    | in  | tvalid/tready         | tdata: point_x, point_y, point_z (96 bits)
// m_axis    | out | tvalid/tready         | tdata: voxel_x/y/z, weight_000..weight_111
// cfg       | in  | cfg_wr_en             | cfg_addr register index, cfg_wdata value
//
// one point per cycle sustained while m_axis_tready stays high; from input request to
// output register a point passes the translate, scale, round, pair product, triple
// product and weight rounding stages
// each stage holds its own valid bit, so an empty stage still takes a request while
// the output waits; a stall holds a full stage in place only while all later stages
// are full; rst_n clears the valid bits and the configuration registers asynchronously
module point_to_voxel_trilinear_weights_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // point_x [31:0], point_y [63:32], point_z [95:64]
    input  logic [95:0]                   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // voxel_x, voxel_y, voxel_z (16 each), weight_000 .. weight_111 (17 each)
    output logic [183:0]                  m_axis_tdata,
    input  logic                          cfg_wr_en,
    input  logic [ptv_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [ptv_pkg::CFG_DW-1:0]    cfg_wdata
);
    import ptv_pkg::*;

    logic signed [SHIFT_W-1:0] shift_reg [3];
    logic [INV_W-1:0]          inv_reg [3];
    logic                      mode_reg;
    pipe_ctrl_t                ctrl;
    coord_t [2:0]              coord_mid;
    weight_t [2:0][1:0]        factor;
    coord_t [2:0]              coord_out;
    weight_t [7:0]             weight;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                shift_reg[k] <= '0;
                inv_reg[k]   <= INV_ONE;
            end
            mode_reg <= MODE_NEAREST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_SHIFT_X: shift_reg[0] <= cfg_wdata;
                REG_SHIFT_Y: shift_reg[1] <= cfg_wdata;
                REG_SHIFT_Z: shift_reg[2] <= cfg_wdata;
                REG_INV_X:   inv_reg[0]   <= cfg_wdata[INV_W-1:0];
                REG_INV_Y:   inv_reg[1]   <= cfg_wdata[INV_W-1:0];
                REG_INV_Z:   inv_reg[2]   <= cfg_wdata[INV_W-1:0];
                REG_MODE:    mode_reg     <= cfg_wdata[0];
                default:     ;
            endcase
        end
    end

    // handshake and stage valid bits
    ptv_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .m_ready (m_axis_tready),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .ctrl    (ctrl)
    );

    // per-axis translate, scale and round
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        ptv_axis u_axis (
            .clk      (clk),
            .ctrl     (ctrl),
            .mode     (mode_reg),
            .point    (s_axis_tdata[a*POINT_W +: POINT_W]),
            .shift    (shift_reg[a]),
            .inv_size (inv_reg[a]),
            .coord    (coord_mid[a]),
            .w_lo     (factor[a][0]),
            .w_hi     (factor[a][1])
        );
    end

    // corner weight products and output register
    ptv_weight u_weight (
        .clk       (clk),
        .ctrl      (ctrl),
        .mode      (mode_reg),
        .coord_in  (coord_mid),
        .factor    (factor),
        .coord_out (coord_out),
        .weight    (weight)
    );

    assign m_axis_tdata = {weight, coord_out};

endmodule
